/* hw/rtl/tbli_pkg.sv */
// Shared types, constants and the cell width function for the text block layout indexer.
`default_nettype none

package tbli_pkg;

    localparam int CNT_W     = 21;
    localparam int LEN_W     = 11;
    localparam int CELLS_W   = 13;
    localparam int TOTAL_W   = 23;
    localparam int COLS_W    = 10;
    localparam int UNIT_W    = 16;
    localparam int CW_W      = 3;
    localparam int DIVD_W    = CELLS_W + 1;
    localparam int DIV_CNT_W = 4;
    localparam int ADDR_W    = 3;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 4'd14;

    localparam logic [CNT_W-1:0]   CNT_MAX    = 21'h1F_FFFF;
    localparam logic [CELLS_W-1:0] CELLS_MAX  = 13'h1FFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 23'h7F_FFFF;
    localparam logic [LEN_W-1:0]   MAX_CHUNK  = 11'd1024;
    localparam logic [CW_W-1:0]    TAB_CELLS  = 3'd4;

    localparam logic [LEN_W-1:0]   CHUNK_RESET   = 11'd64;
    localparam logic [COLS_W-1:0]  COLUMNS_RESET = 10'd0;

    // register select is the word address bit
    localparam logic REG_CHUNK_SIZE = 1'b0;
    localparam logic REG_COLUMNS    = 1'b1;

    localparam logic [UNIT_W-1:0] CU_NEWLINE = 16'h000A;
    localparam logic [UNIT_W-1:0] CU_TAB     = 16'h0009;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_step;
        logic apply;
        logic use_latched;
    } t_cmd;

    typedef struct packed {
        logic need_emit;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic [CW_W-1:0] unit_cells(input logic [UNIT_W-1:0] c);
        logic [CW_W-1:0] w;
        w = 3'd1;
        if (c == CU_TAB) begin
            w = TAB_CELLS;
        end else if (c >= 16'hDC00 && c <= 16'hDFFF) begin
            w = 3'd0;
        end else if (c >= 16'hD800 && c <= 16'hDBFF) begin
            w = 3'd2;
        end else if ((c >= 16'h1100 && c <= 16'h115F) || (c >= 16'h2E80 && c <= 16'hA4CF) ||
                     (c >= 16'hAC00 && c <= 16'hD7A3) || (c >= 16'hF900 && c <= 16'hFAFF) ||
                     (c >= 16'hFE30 && c <= 16'hFE4F) || (c >= 16'hFF00 && c <= 16'hFF60) ||
                     (c >= 16'hFFE0 && c <= 16'hFFE6)) begin
            w = 3'd2;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tbli_ctrl.sv */
// Controller state machine: accepts requests, sequences the row divider and block emission.
`default_nettype none

module tbli_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire tbli_pkg::t_sts i_sts,
    output tbli_pkg::t_cmd     o_cmd
);

    tbli_pkg::t_state r_state;
    tbli_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbli_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            tbli_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_sts.need_emit) begin
                        // closing a block: run the row divider first
                        o_cmd.capture   = 1'b1;
                        o_cmd.div_start = 1'b1;
                        n_state         = tbli_pkg::ST_DIV;
                    end else begin
                        o_cmd.apply = 1'b1;
                    end
                end
            end
            tbli_pkg::ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = tbli_pkg::ST_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            tbli_pkg::ST_FIN: begin
                o_cmd.use_latched = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = tbli_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tbli_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/tbli_datapath.sv */
// Datapath: position and block counters, cell accumulation, row divider and output register.
`default_nettype none

module tbli_datapath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [tbli_pkg::LEN_W-1:0]            i_chunk_size,
    input  wire logic [tbli_pkg::COLS_W-1:0]           i_columns,
    input  wire logic [tbli_pkg::UNIT_W-1:0]           i_code_unit,
    input  wire logic                                  i_end_of_text,
    input  wire tbli_pkg::t_cmd                        i_cmd,
    output tbli_pkg::t_sts                             o_sts,
    input  wire logic                                  i_out_stall,
    output logic                                       o_out_valid,
    output logic [tbli_pkg::CNT_W-1:0]                 o_block_index,
    output logic [tbli_pkg::CNT_W-1:0]                 o_line_index,
    output logic [tbli_pkg::CNT_W-1:0]                 o_chunk_in_line,
    output logic [tbli_pkg::CNT_W-1:0]                 o_block_start,
    output logic [tbli_pkg::LEN_W-1:0]                 o_block_length,
    output logic [tbli_pkg::CELLS_W-1:0]               o_block_cells,
    output logic [tbli_pkg::CELLS_W-1:0]               o_block_rows,
    output logic [tbli_pkg::TOTAL_W-1:0]               o_rows_before,
    output logic                                       o_last_block
);

    // document state
    logic [tbli_pkg::CNT_W-1:0]   r_pos, r_line, r_chunk, r_bcnt, r_start;
    logic [tbli_pkg::LEN_W-1:0]   r_len;
    logic [tbli_pkg::CELLS_W-1:0] r_cells;
    logic [tbli_pkg::TOTAL_W-1:0] r_total;
    logic [tbli_pkg::CNT_W-1:0]   n_pos, n_line, n_chunk, n_bcnt, n_start;
    logic [tbli_pkg::LEN_W-1:0]   n_len;
    logic [tbli_pkg::CELLS_W-1:0] n_cells;
    logic [tbli_pkg::TOTAL_W-1:0] n_total;

    // held request while the divider runs
    logic [tbli_pkg::UNIT_W-1:0]  r_unit;
    logic                         r_eot;

    // divider
    logic [tbli_pkg::DIVD_W-1:0]    r_quo;
    logic [tbli_pkg::COLS_W-1:0]    r_rem;
    logic [tbli_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [tbli_pkg::COLS_W:0]      w_trial;
    logic                           w_fits;
    logic [tbli_pkg::DIVD_W-1:0]    w_dividend;

    logic                           r_out_valid;
    logic [tbli_pkg::UNIT_W-1:0]    w_unit;
    logic                           w_eot;
    logic                           w_lf;
    logic                           w_full;
    logic [tbli_pkg::LEN_W-1:0]     w_eff;
    logic [tbli_pkg::CW_W-1:0]      w_cw;
    logic [tbli_pkg::DIVD_W-1:0]    w_cell_sum;
    logic [tbli_pkg::CELLS_W-1:0]   w_cells_add;
    logic [tbli_pkg::CELLS_W-1:0]   w_rows;
    logic [tbli_pkg::TOTAL_W:0]     w_total_sum;
    logic [tbli_pkg::TOTAL_W-1:0]   w_total_add;
    logic [tbli_pkg::CNT_W-1:0]     w_pos_inc;

    assign w_unit = i_cmd.use_latched ? r_unit : i_code_unit;
    assign w_eot  = i_cmd.use_latched ? r_eot  : i_end_of_text;
    assign w_lf   = (w_unit == tbli_pkg::CU_NEWLINE);

    always_comb begin
        if (i_chunk_size == '0) begin
            w_eff = 11'd1;
        end else if (i_chunk_size > tbli_pkg::MAX_CHUNK) begin
            w_eff = tbli_pkg::MAX_CHUNK;
        end else begin
            w_eff = i_chunk_size;
        end
    end

    assign w_full = (r_len >= w_eff);

    assign o_sts.need_emit = w_eot | w_lf | w_full;
    assign o_sts.div_done  = (r_div_cnt == '0);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // ceil(cells / columns) as floor((cells + columns - 1) / columns), one bit per cycle
    assign w_dividend = {1'b0, r_cells} + {{(tbli_pkg::DIVD_W-tbli_pkg::COLS_W){1'b0}}, i_columns}
                        - {{(tbli_pkg::DIVD_W-1){1'b0}}, 1'b1};
    assign w_trial    = {r_rem, r_quo[tbli_pkg::DIVD_W-1]};
    assign w_fits     = (w_trial >= {1'b0, i_columns});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= tbli_pkg::DIV_STEPS;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= w_dividend;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_fits ? tbli_pkg::COLS_W'(w_trial - {1'b0, i_columns})
                            : w_trial[tbli_pkg::COLS_W-1:0];
            r_quo <= {r_quo[tbli_pkg::DIVD_W-2:0], w_fits};
        end
        if (i_cmd.capture) begin
            r_unit <= i_code_unit;
            r_eot  <= i_end_of_text;
        end
    end

    always_comb begin
        if (i_columns == '0 || r_quo == '0) begin
            w_rows = 13'd1;
        end else begin
            w_rows = r_quo[tbli_pkg::CELLS_W-1:0];
        end
    end

    assign w_total_sum = {1'b0, r_total} + {{(tbli_pkg::TOTAL_W+1-tbli_pkg::CELLS_W){1'b0}}, w_rows};
    assign w_total_add = (w_total_sum > {1'b0, tbli_pkg::TOTAL_MAX}) ? tbli_pkg::TOTAL_MAX
                                                                     : w_total_sum[tbli_pkg::TOTAL_W-1:0];
    assign w_pos_inc   = (r_pos == tbli_pkg::CNT_MAX) ? r_pos : r_pos + 1'b1;

    // a block that closes on a full length restarts from zero cells
    assign w_cw        = tbli_pkg::unit_cells(w_unit);
    assign w_cell_sum  = {1'b0, (w_full ? '0 : r_cells)}
                         + {{(tbli_pkg::DIVD_W-tbli_pkg::CW_W){1'b0}}, w_cw};
    assign w_cells_add = (w_cell_sum > {1'b0, tbli_pkg::CELLS_MAX}) ? tbli_pkg::CELLS_MAX
                                                                    : w_cell_sum[tbli_pkg::CELLS_W-1:0];

    always_comb begin
        n_pos   = r_pos;
        n_line  = r_line;
        n_chunk = r_chunk;
        n_bcnt  = r_bcnt;
        n_start = r_start;
        n_len   = r_len;
        n_cells = r_cells;
        n_total = r_total;
        if (w_eot) begin
            n_pos   = '0;
            n_line  = '0;
            n_chunk = '0;
            n_bcnt  = '0;
            n_start = '0;
            n_len   = '0;
            n_cells = '0;
            n_total = '0;
        end else begin
            if (o_sts.need_emit) begin
                n_total = w_total_add;
                n_bcnt  = (r_bcnt == tbli_pkg::CNT_MAX) ? r_bcnt : r_bcnt + 1'b1;
            end
            n_pos = w_pos_inc;
            if (w_lf) begin
                n_line  = (r_line == tbli_pkg::CNT_MAX) ? r_line : r_line + 1'b1;
                n_chunk = '0;
                n_start = w_pos_inc;
                n_len   = '0;
                n_cells = '0;
            end else if (w_full) begin
                n_chunk = (r_chunk == tbli_pkg::CNT_MAX) ? r_chunk : r_chunk + 1'b1;
                n_start = r_pos;
                n_len   = 11'd1;
                n_cells = w_cells_add;
            end else begin
                n_len   = r_len + 1'b1;
                n_cells = w_cells_add;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_line  <= '0;
            r_chunk <= '0;
            r_bcnt  <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_cells <= '0;
            r_total <= '0;
        end else if (i_cmd.apply) begin
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_chunk <= n_chunk;
            r_bcnt  <= n_bcnt;
            r_start <= n_start;
            r_len   <= n_len;
            r_cells <= n_cells;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply && o_sts.need_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && o_sts.need_emit) begin
            o_block_index   <= r_bcnt;
            o_line_index    <= r_line;
            o_chunk_in_line <= r_chunk;
            o_block_start   <= r_start;
            o_block_length  <= r_len;
            o_block_cells   <= r_cells;
            o_block_rows    <= w_rows;
            o_rows_before   <= r_total;
            o_last_block    <= w_eot;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* hw/rtl/text_block_layout_indexer_core.sv */
// Top level of the text block layout indexer: register port, controller and datapath.
`default_nettype none

// A code unit that leaves its block open is taken in the idle state, so plain text streams at
// one request per clock. A request that closes a block (newline, a unit arriving at a full
// block, or the end marker) passes through the accept cycle, 14 steps of the bit-serial row
// divider that forms ceil(cells / columns), a state in which the controller sees the step count
// run out, and a finish state that loads the output register and waits further while a previous
// result is still held by a stalled consumer. chunk_size (address 0) and columns (address 4) are
// written through the APB port only while idle; the user must ensure this, the block does not.
module text_block_layout_indexer_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [tbli_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [31:0]                           pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [tbli_pkg::UNIT_W-1:0]           i_code_unit,
    input  wire logic                                  i_end_of_text,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [tbli_pkg::CNT_W-1:0]                 o_block_index,
    output logic [tbli_pkg::CNT_W-1:0]                 o_line_index,
    output logic [tbli_pkg::CNT_W-1:0]                 o_chunk_in_line,
    output logic [tbli_pkg::CNT_W-1:0]                 o_block_start,
    output logic [tbli_pkg::LEN_W-1:0]                 o_block_length,
    output logic [tbli_pkg::CELLS_W-1:0]               o_block_cells,
    output logic [tbli_pkg::CELLS_W-1:0]               o_block_rows,
    output logic [tbli_pkg::TOTAL_W-1:0]               o_rows_before,
    output logic                                       o_last_block
);

    logic [tbli_pkg::LEN_W-1:0]  r_chunk_size;
    logic [tbli_pkg::COLS_W-1:0] r_columns;
    logic                        w_wr;
    tbli_pkg::t_cmd              w_cmd;
    tbli_pkg::t_sts              w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size <= tbli_pkg::CHUNK_RESET;
            r_columns    <= tbli_pkg::COLUMNS_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                tbli_pkg::REG_CHUNK_SIZE: r_chunk_size <= pwdata[tbli_pkg::LEN_W-1:0];
                tbli_pkg::REG_COLUMNS:    r_columns    <= pwdata[tbli_pkg::COLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tbli_pkg::REG_CHUNK_SIZE: prdata = {{(32-tbli_pkg::LEN_W){1'b0}}, r_chunk_size};
            tbli_pkg::REG_COLUMNS:    prdata = {{(32-tbli_pkg::COLS_W){1'b0}}, r_columns};
            default:                  prdata = '0;
        endcase
    end

    tbli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tbli_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_chunk_size    (r_chunk_size),
        .i_columns       (r_columns),
        .i_code_unit     (i_code_unit),
        .i_end_of_text   (i_end_of_text),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_block_index   (o_block_index),
        .o_line_index    (o_line_index),
        .o_chunk_in_line (o_chunk_in_line),
        .o_block_start   (o_block_start),
        .o_block_length  (o_block_length),
        .o_block_cells   (o_block_cells),
        .o_block_rows    (o_block_rows),
        .o_rows_before   (o_rows_before),
        .o_last_block    (o_last_block)
    );

    // a closing request never takes the direct update path in the idle state
    a_fast_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.apply && !w_cmd.use_latched) |-> !w_sts.need_emit)
        else $error("single-cycle update on a closing request");

    // a new result only appears after a finish cycle
    a_out_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.apply && w_cmd.use_latched))
        else $error("result appeared without a finish cycle");

    // divider never steps past its count
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_step |-> !w_sts.div_done)
        else $error("divider stepped after completion");

    a_rows_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_block_rows != '0))
        else $error("block reported with zero rows");

endmodule

`default_nettype wire

/* tb/sv/text_block_layout_indexer_core_test.sv */
// Self-checking testbench for the text block layout indexer core.
`timescale 1ns / 1ps

module text_block_layout_indexer_core_test;

    localparam logic [tbli_pkg::ADDR_W-1:0] ADDR_CHUNK   = {tbli_pkg::REG_CHUNK_SIZE, 2'b00};
    localparam logic [tbli_pkg::ADDR_W-1:0] ADDR_COLUMNS = {tbli_pkg::REG_COLUMNS, 2'b00};
    localparam int PHASES = 10;

    typedef struct {
        logic [tbli_pkg::CNT_W-1:0]   blk_idx;
        logic [tbli_pkg::CNT_W-1:0]   line_no;
        logic [tbli_pkg::CNT_W-1:0]   chunk_no;
        logic [tbli_pkg::CNT_W-1:0]   start_pos;
        logic [tbli_pkg::LEN_W-1:0]   len;
        logic [tbli_pkg::CELLS_W-1:0] cells;
        logic [tbli_pkg::CELLS_W-1:0] rows;
        logic [tbli_pkg::TOTAL_W-1:0] rows_prior;
        logic                         last;
    } t_block_rec;

    // Tracks the layout state, predicts closed blocks and checks them in order.
    class t_layout_ledger;
        logic [tbli_pkg::LEN_W-1:0]  chunk_reg;
        logic [tbli_pkg::COLS_W-1:0] cols_reg;
        logic [tbli_pkg::CNT_W-1:0]  pos, line_no, chunk_no, blk_no, open_start;
        int unsigned                 open_len, open_cells, row_sum;
        t_block_rec                  pending_blocks[$];
        int                          failures, shown, checked;

        function new();
            chunk_reg = 11'd64;
            cols_reg  = '0;
            failures  = 0;
            shown     = 0;
            checked   = 0;
            restart();
        endfunction

        function void restart();
            pos        = '0;
            line_no    = '0;
            chunk_no   = '0;
            blk_no     = '0;
            open_start = '0;
            open_len   = 0;
            open_cells = 0;
            row_sum    = 0;
        endfunction

        function int unsigned width_of(logic [tbli_pkg::UNIT_W-1:0] u);
            if (u == tbli_pkg::CU_TAB) return 4;
            if (u[15:10] == 6'b110111) return 0;   // low surrogate
            if (u[15:10] == 6'b110110) return 2;   // high surrogate
            if ((u >= 16'h1100 && u <= 16'h115F) || (u >= 16'h2E80 && u <= 16'hA4CF) ||
                (u >= 16'hAC00 && u <= 16'hD7A3) || (u >= 16'hF900 && u <= 16'hFAFF) ||
                (u >= 16'hFE30 && u <= 16'hFE4F) || (u >= 16'hFF00 && u <= 16'hFF60) ||
                (u >= 16'hFFE0 && u <= 16'hFFE6))
                return 2;
            return 1;
        endfunction

        function int unsigned eff_chunk();
            if (chunk_reg == 0) return 1;
            if (chunk_reg > 1024) return 1024;
            return 32'(chunk_reg);
        endfunction

        function logic [tbli_pkg::CNT_W-1:0] bump(logic [tbli_pkg::CNT_W-1:0] v);
            return (v == tbli_pkg::CNT_MAX) ? v : v + 1'b1;
        endfunction

        function void close_block(bit last);
            t_block_rec  b;
            int unsigned rows;
            rows = 1;
            if (cols_reg != 0) begin
                rows = (open_cells + cols_reg - 1) / cols_reg;
                if (rows == 0) rows = 1;
            end
            b.blk_idx    = blk_no;
            b.line_no    = line_no;
            b.chunk_no   = chunk_no;
            b.start_pos  = open_start;
            b.len        = open_len[tbli_pkg::LEN_W-1:0];
            b.cells      = open_cells[tbli_pkg::CELLS_W-1:0];
            b.rows       = rows[tbli_pkg::CELLS_W-1:0];
            b.rows_prior = row_sum[tbli_pkg::TOTAL_W-1:0];
            b.last       = last;
            row_sum = (row_sum + rows > 32'h7F_FFFF) ? 32'h7F_FFFF : row_sum + rows;
            blk_no  = bump(blk_no);
            pending_blocks.push_back(b);
        endfunction

        function void note_unit(logic [tbli_pkg::UNIT_W-1:0] u, logic eot);
            if (eot) begin
                close_block(1'b1);
                restart();
            end else if (u == tbli_pkg::CU_NEWLINE) begin
                close_block(1'b0);
                line_no    = bump(line_no);
                chunk_no   = '0;
                pos        = bump(pos);
                open_start = pos;
                open_len   = 0;
                open_cells = 0;
            end else begin
                // full block (possibly after a smaller chunk size was set) closes first
                if (open_len >= eff_chunk()) begin
                    close_block(1'b0);
                    chunk_no   = bump(chunk_no);
                    open_start = pos;
                    open_len   = 0;
                    open_cells = 0;
                end
                open_len   = open_len + 1;
                open_cells = open_cells + width_of(u);
                if (open_cells > 8191) open_cells = 8191;
                pos = bump(pos);
            end
        endfunction

        function void flag(string what);
            failures++;
            if (shown < 10) begin
                shown++;
                $display("mismatch: %s", what);
            end
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
                flag($sformatf("block %0d %s: expected %0d, got %0d", checked, name, want, got));
        endfunction

        function void check_block(t_block_rec got);
            t_block_rec want;
            if (pending_blocks.size() == 0) begin
                flag($sformatf("unexpected block, index %0d", got.blk_idx));
                return;
            end
            want = pending_blocks.pop_front();
            match_field("block_index", 32'(want.blk_idx), 32'(got.blk_idx));
            match_field("line_index", 32'(want.line_no), 32'(got.line_no));
            match_field("chunk_in_line", 32'(want.chunk_no), 32'(got.chunk_no));
            match_field("block_start", 32'(want.start_pos), 32'(got.start_pos));
            match_field("block_length", 32'(want.len), 32'(got.len));
            match_field("block_cells", 32'(want.cells), 32'(got.cells));
            match_field("block_rows", 32'(want.rows), 32'(got.rows));
            match_field("rows_before", 32'(want.rows_prior), 32'(got.rows_prior));
            match_field("last_block", 32'(want.last), 32'(got.last));
            checked++;
        endfunction

        function int pending();
            return pending_blocks.size();
        endfunction

        function bit clean();
            return failures == 0 && pending_blocks.size() == 0;
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           psel, penable, pwrite;
    logic [tbli_pkg::ADDR_W-1:0]    paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [tbli_pkg::UNIT_W-1:0]    i_code_unit;
    logic                           i_end_of_text;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [tbli_pkg::CNT_W-1:0]     o_block_index, o_line_index, o_chunk_in_line, o_block_start;
    logic [tbli_pkg::LEN_W-1:0]     o_block_length;
    logic [tbli_pkg::CELLS_W-1:0]   o_block_cells, o_block_rows;
    logic [tbli_pkg::TOTAL_W-1:0]   o_rows_before;
    logic                           o_last_block;

    t_layout_ledger ledger;
    bit calm;           // no idling on either side
    bit tx_quiet;
    int hold_asks;      // bumped to ask the receiver for one long hold-off

    text_block_layout_indexer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_code_unit     (i_code_unit),
        .i_end_of_text   (i_end_of_text),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_block_index   (o_block_index),
        .o_line_index    (o_line_index),
        .o_chunk_in_line (o_chunk_in_line),
        .o_block_start   (o_block_start),
        .o_block_length  (o_block_length),
        .o_block_cells   (o_block_cells),
        .o_block_rows    (o_block_rows),
        .o_rows_before   (o_rows_before),
        .o_last_block    (o_last_block)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin : take_block
        t_block_rec got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.blk_idx    = o_block_index;
            got.line_no    = o_line_index;
            got.chunk_no   = o_chunk_in_line;
            got.start_pos  = o_block_start;
            got.len        = o_block_length;
            got.cells      = o_block_cells;
            got.rows       = o_block_rows;
            got.rows_prior = o_rows_before;
            got.last       = o_last_block;
            ledger.check_block(got);
        end
    end

    // receiver: random stall bursts, quiet stretches, and the long hold-off on request
    initial begin
        int left;
        int seen;
        bit quiet;
        i_out_stall = 1'b0;
        left  = 0;
        seen  = 0;
        quiet = 0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != seen) begin
                seen = hold_asks;
                left = 300;
            end
            if (left > 0) begin
                i_out_stall = 1'b1;
                left--;
            end else begin
                i_out_stall = 1'b0;
                if ($urandom_range(0, 63) == 0) quiet = !quiet;
                if (!calm && !quiet && $urandom_range(0, 5) == 0)
                    left = int'($urandom_range(1, 6));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("text_block_layout_indexer_core_test NOT OK");
        $finish;
    end

    task automatic tx_gap(int n);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_unit(logic [tbli_pkg::UNIT_W-1:0] u, logic eot);
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_code_unit   = u;
        i_end_of_text = eot;
        do @(posedge i_clk); while (o_in_stall);
        ledger.note_unit(u, eot);
        if (!calm && !tx_quiet && $urandom_range(0, 7) == 0) tx_gap(int'($urandom_range(1, 6)));
    endtask

    // wait for every block to come out, then let the divider settle
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    // register write followed by a readback
    task automatic set_reg(logic [tbli_pkg::ADDR_W-1:0] addr, logic [31:0] value);
        logic [31:0] want;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_CHUNK) begin
            ledger.chunk_reg = value[tbli_pkg::LEN_W-1:0];
            want = 32'(value[tbli_pkg::LEN_W-1:0]);
        end else begin
            ledger.cols_reg = value[tbli_pkg::COLS_W-1:0];
            want = 32'(value[tbli_pkg::COLS_W-1:0]);
        end
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_CHUNK)
            ledger.match_field("chunk_size readback", want,
                               32'(prdata[tbli_pkg::LEN_W-1:0]));
        else
            ledger.match_field("columns readback", want, 32'(prdata[tbli_pkg::COLS_W-1:0]));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [tbli_pkg::UNIT_W-1:0] random_unit();
        int unsigned v;
        case ($urandom_range(0, 11))
            0: v = 32'(tbli_pkg::CU_TAB);
            1: v = 32'hD800 + $urandom_range(0, 1023);
            2: v = 32'hDC00 + $urandom_range(0, 1023);
            3: begin
                case ($urandom_range(0, 6))
                    0: v = $urandom_range(32'h1100, 32'h115F);
                    1: v = $urandom_range(32'h2E80, 32'hA4CF);
                    2: v = $urandom_range(32'hAC00, 32'hD7A3);
                    3: v = $urandom_range(32'hF900, 32'hFAFF);
                    4: v = $urandom_range(32'hFE30, 32'hFE4F);
                    5: v = $urandom_range(32'hFF00, 32'hFF60);
                    default: v = $urandom_range(32'hFFE0, 32'hFFE6);
                endcase
            end
            4, 5: v = $urandom_range(0, 65535);
            default: v = $urandom_range(32, 126);
        endcase
        return v[tbli_pkg::UNIT_W-1:0];
    endfunction

    // random lines of random text; mostly newline-terminated, some end markers
    task automatic run_text(int n);
        int          sent;
        int          len;
        int          k;
        int          r;
        int unsigned eff;
        int unsigned cap;
        sent = 0;
        while (sent < n) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            eff = ledger.eff_chunk();
            cap = (eff * 3 > 48) ? 48 : eff * 3;
            r = int'($urandom_range(0, 7));
            if (r == 0)
                len = 0;
            else if (r == 1 && eff <= 128)
                len = int'(eff + $urandom_range(0, 1));
            else
                len = int'($urandom_range(1, cap));
            for (k = 0; k < len && sent < n; k++) begin
                send_unit(random_unit(), 1'b0);
                sent++;
            end
            if (sent < n) begin
                r = int'($urandom_range(0, 19));
                if (r < 16) begin
                    send_unit(tbli_pkg::CU_NEWLINE, 1'b0);
                    sent++;
                end else if (r < 18) begin
                    send_unit(random_unit(), 1'b1);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        logic [tbli_pkg::UNIT_W-1:0] edge_probe [0:21];
        logic [10:0]                 chunk_plan [0:PHASES-1];
        logic [9:0]                  cols_plan  [0:PHASES-1];
        int                          i;

        ledger        = new();
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_code_unit   = '0;
        i_end_of_text = 1'b0;
        calm          = 0;
        tx_quiet      = 0;
        hold_asks     = 0;

        edge_probe = '{16'h0000, 16'hFFFF, 16'h0009, 16'h10FF, 16'h1100, 16'h115F,
                       16'h2E80, 16'hA4CF, 16'hAC00, 16'hD7A3, 16'hD800, 16'hDBFF,
                       16'hDC00, 16'hDFFF, 16'hF900, 16'hFAFF, 16'hFE30, 16'hFE4F,
                       16'hFF00, 16'hFF60, 16'hFFE0, 16'hFFE6};
        chunk_plan = '{11'd5, 11'd0, 11'd1, 11'd2047, 11'd1024,
                       11'd3, 11'd1023, 11'd64, 11'd7, 11'd2};
        cols_plan  = '{10'd1, 10'd0, 10'd3, 10'd1023, 10'd80,
                       10'd7, 10'd2, 10'd0, 10'd1, 10'd5};

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty document, empty line, cell width edges, end marker carrying a newline unit
        send_unit(16'hFFFF, 1'b1);
        send_unit(tbli_pkg::CU_NEWLINE, 1'b0);
        foreach (edge_probe[j]) send_unit(edge_probe[j], 1'b0);
        send_unit(tbli_pkg::CU_NEWLINE, 1'b0);
        send_unit(tbli_pkg::CU_NEWLINE, 1'b1);
        drain();

        // leave a long block open, then shrink the chunk size under it
        for (i = 0; i < 12; i++) send_unit(random_unit() | 16'h0100, 1'b0);
        drain();

        for (i = 0; i < PHASES; i++) begin
            if (i == PHASES - 1) calm = 1;
            if (i == 8) begin
                chunk_plan[i] = 11'($urandom_range(1, 40));
                cols_plan[i]  = 10'($urandom_range(0, 1023));
            end
            set_reg(ADDR_CHUNK, 32'(chunk_plan[i]));
            set_reg(ADDR_COLUMNS, 32'(cols_plan[i]));
            // every unit but the first of each line closes a block here, so a long output hold-off backs up the input
            if (chunk_plan[i] == 11'd1) hold_asks++;
            run_text(90);
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (ledger.clean())
            $display("text_block_layout_indexer_core_test OK");
        else
            $display("text_block_layout_indexer_core_test NOT OK");
        $finish;
    end

endmodule
